### sv/resch_pkg.sv
// Package: shared constants, types and time-compare functions of the event scheduler.
package resch_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int TIME_BITS   = 32;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int ID_W        = 8;
  localparam int FUNC_W      = 3;
  localparam int ST_W        = 3;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_INSERT  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_LIMITED = 3'd1;
  localparam logic [FUNC_W-1:0] FN_PREEMPT = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REMOVE  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_POP     = 3'd4;
  localparam logic [FUNC_W-1:0] FN_PEEK    = 3'd5;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_REJECTED = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd4;

  // result kinds
  localparam logic RK_STATUS = 1'b0;
  localparam logic RK_EVICT  = 1'b1;

  // result source select
  localparam logic [1:0] EMIT_NONE = 2'd0;
  localparam logic [1:0] EMIT_SLOT = 2'd1;
  localparam logic [1:0] EMIT_STAT = 2'd2;
  localparam logic [1:0] EMIT_NEW  = 2'd3;

  typedef struct packed {
    logic [TIME_BITS-1:0] t_start;
    logic [TIME_BITS-1:0] t_end;
    logic [ID_W-1:0]      id;
    logic                 kind;
  } slot_t;

  typedef struct packed {
    logic            load;
    logic            adv;
    logic            slide;
    logic            ins;
    logic            rem;
    logic [1:0]      emit_sel;
    logic            rk;
    logic [ST_W-1:0] st;
    logic            last;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              at_end;
    logic              le_hit;
    logic              ovl;
    logic              slot_adv;
    logic              id_hit;
    logic              full;
    logic              empty;
    logic              over_lim;
  } sts_t;

  // a - b < 0 in wrapping time
  function automatic logic t_lt(input logic [TIME_BITS-1:0] a, input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS-1:0] d;
    d = a - b;
    return d[TIME_BITS-1];
  endfunction

  // a - b <= 0 in wrapping time
  function automatic logic t_le(input logic [TIME_BITS-1:0] a, input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS-1:0] d;
    d = a - b;
    return (d == '0) || d[TIME_BITS-1];
  endfunction

endpackage

### sv/resch_in_if.sv
// Interface: request channel of the event scheduler.
interface resch_in_if;
  logic                               valid;
  logic                               ready;
  logic [resch_pkg::FUNC_W-1:0]       func;
  logic [resch_pkg::ID_W-1:0]         item_id;
  logic                               item_kind;
  logic [resch_pkg::TIME_BITS-1:0]    start_tick;
  logic [resch_pkg::TIME_BITS-1:0]    duration;
  logic [resch_pkg::TIME_BITS-1:0]    shift_limit;

  modport source (output valid, func, item_id, item_kind, start_tick, duration, shift_limit,
                  input ready);
  modport sink (input valid, func, item_id, item_kind, start_tick, duration, shift_limit,
                output ready);
endinterface

### sv/resch_out_if.sv
// Interface: result channel of the event scheduler.
interface resch_out_if;
  logic                               valid;
  logic                               ready;
  logic                               result_kind;
  logic [resch_pkg::ST_W-1:0]         status;
  logic [resch_pkg::ID_W-1:0]         entry_id;
  logic                               entry_kind;
  logic [resch_pkg::TIME_BITS-1:0]    granted_start;
  logic [resch_pkg::TIME_BITS-1:0]    granted_end;
  logic [resch_pkg::TIME_BITS-1:0]    slide_ticks;
  logic                               last;

  modport source (output valid, result_kind, status, entry_id, entry_kind, granted_start,
                  granted_end, slide_ticks, last, input ready);
  modport sink (input valid, result_kind, status, entry_id, entry_kind, granted_start,
                granted_end, slide_ticks, last, output ready);
endinterface

### sv/resch_dp.sv
// Datapath: event table, walk index, working times and the result register.
module resch_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  resch_pkg::cmd_t                  cmd,
  output resch_pkg::sts_t                  sts,
  input  logic [resch_pkg::FUNC_W-1:0]     in_func,
  input  logic [resch_pkg::ID_W-1:0]       in_id,
  input  logic                             in_kind,
  input  logic [resch_pkg::TIME_BITS-1:0]  in_start,
  input  logic [resch_pkg::TIME_BITS-1:0]  in_dur,
  input  logic [resch_pkg::TIME_BITS-1:0]  in_lim,
  output logic                             res_kind,
  output logic [resch_pkg::ST_W-1:0]       res_status,
  output logic [resch_pkg::ID_W-1:0]       res_id,
  output logic                             res_entry_kind,
  output logic [resch_pkg::TIME_BITS-1:0]  res_start,
  output logic [resch_pkg::TIME_BITS-1:0]  res_end,
  output logic [resch_pkg::TIME_BITS-1:0]  res_slide,
  output logic                             res_last
);

  resch_pkg::slot_t                   tbl_r [resch_pkg::TABLE_DEPTH];
  logic [resch_pkg::CNT_W-1:0]        cnt_r;
  logic [resch_pkg::CNT_W-1:0]        idx_r;
  logic [resch_pkg::TIME_BITS-1:0]    s_r;
  logic [resch_pkg::TIME_BITS-1:0]    e_r;
  logic [resch_pkg::TIME_BITS-1:0]    start_r;
  logic [resch_pkg::TIME_BITS-1:0]    dur_r;
  logic [resch_pkg::TIME_BITS-1:0]    lim_r;
  logic [resch_pkg::ID_W-1:0]         id_r;
  logic                               kind_r;
  logic [resch_pkg::FUNC_W-1:0]       func_r;
  resch_pkg::slot_t                   rd;
  resch_pkg::slot_t                   new_slot;
  logic [resch_pkg::TIME_BITS-1:0]    slide_amt;

  // read the entry under the walk index
  assign rd        = tbl_r[idx_r[resch_pkg::IDX_W-1:0]];
  assign slide_amt = s_r - start_r;
  assign new_slot  = '{t_start: s_r, t_end: e_r, id: id_r, kind: kind_r};

  // status toward the controller
  always_comb begin
    sts.func     = func_r;
    sts.at_end   = (idx_r == cnt_r);
    sts.le_hit   = resch_pkg::t_le(e_r, rd.t_start);
    sts.ovl      = resch_pkg::t_lt(s_r, rd.t_start) ? !resch_pkg::t_le(e_r, rd.t_start)
                                                     : resch_pkg::t_lt(s_r, rd.t_end);
    sts.slot_adv = rd.kind;
    sts.id_hit   = (rd.id == id_r);
    sts.full     = (cnt_r == resch_pkg::CNT_W'(resch_pkg::TABLE_DEPTH));
    sts.empty    = (cnt_r == '0);
    sts.over_lim = (slide_amt > lim_r);
  end

  // count and index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      if (cmd.ins) cnt_r <= cnt_r + 1'b1;
      else if (cmd.rem) cnt_r <= cnt_r - 1'b1;
      if (cmd.load) idx_r <= '0;
      else if (cmd.adv || cmd.slide) idx_r <= idx_r + 1'b1;
    end
  end

  // capture the request and slide the working window
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      id_r    <= in_id;
      kind_r  <= in_kind;
      start_r <= in_start;
      dur_r   <= in_dur;
      lim_r   <= in_lim;
      s_r     <= in_start;
      e_r     <= in_start + in_dur;
    end else if (cmd.slide) begin
      s_r <= rd.t_end;
      e_r <= rd.t_end + dur_r;
    end
  end

  // shift cells open on insert, closed on remove
  for (genvar k = 0; k < resch_pkg::TABLE_DEPTH; k++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.ins) begin
        if (resch_pkg::CNT_W'(k) == idx_r) tbl_r[k] <= new_slot;
        else if (resch_pkg::CNT_W'(k) > idx_r) begin
          if (k > 0) tbl_r[k] <= tbl_r[(k > 0) ? k - 1 : 0];
        end
      end else if (cmd.rem) begin
        if (resch_pkg::CNT_W'(k) >= idx_r && k + 1 < resch_pkg::TABLE_DEPTH)
          tbl_r[k] <= tbl_r[(k + 1 < resch_pkg::TABLE_DEPTH) ? k + 1 : k];
      end
    end
  end

  // load the result register
  always_ff @(posedge clk) begin
    case (cmd.emit_sel)
      resch_pkg::EMIT_SLOT: begin
        res_kind       <= cmd.rk;
        res_status     <= resch_pkg::ST_OK;
        res_id         <= rd.id;
        res_entry_kind <= rd.kind;
        res_start      <= rd.t_start;
        res_end        <= rd.t_end;
        res_slide      <= '0;
        res_last       <= cmd.last;
      end
      resch_pkg::EMIT_STAT: begin
        res_kind       <= resch_pkg::RK_STATUS;
        res_status     <= cmd.st;
        res_id         <= '0;
        res_entry_kind <= 1'b0;
        res_start      <= '0;
        res_end        <= '0;
        res_slide      <= '0;
        res_last       <= 1'b1;
      end
      resch_pkg::EMIT_NEW: begin
        res_kind       <= resch_pkg::RK_STATUS;
        res_status     <= resch_pkg::ST_OK;
        res_id         <= id_r;
        res_entry_kind <= kind_r;
        res_start      <= s_r;
        res_end        <= e_r;
        res_slide      <= slide_amt;
        res_last       <= 1'b1;
      end
      default: begin
        res_kind <= res_kind;
      end
    endcase
  end

endmodule

### sv/resch_ctrl.sv
// Controller: sequences each operation over the table walk and the result handshake.
module resch_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  resch_pkg::sts_t sts,
  output resch_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_WAIT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [1:0] resume_r, resume_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       fin;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign fin       = sts.at_end || sts.le_hit;

  // decode the next step
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    resume_nxt    = resume_r;
    out_valid_nxt = out_valid_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        resume_nxt = S_IDLE;
        if (sts.full && sts.func <= resch_pkg::FN_PREEMPT) begin
          cmd.emit_sel = resch_pkg::EMIT_STAT;
          cmd.st       = resch_pkg::ST_FULL;
        end else if (sts.func <= resch_pkg::FN_REMOVE) begin
          state_nxt = S_WALK;
        end else if (sts.func == resch_pkg::FN_POP || sts.func == resch_pkg::FN_PEEK) begin
          if (sts.empty) begin
            cmd.emit_sel = resch_pkg::EMIT_STAT;
            cmd.st       = resch_pkg::ST_EMPTY;
          end else begin
            cmd.emit_sel = resch_pkg::EMIT_SLOT;
            cmd.rk       = resch_pkg::RK_STATUS;
            cmd.last     = 1'b1;
            cmd.rem      = (sts.func == resch_pkg::FN_POP);
          end
        end else begin
          cmd.emit_sel = resch_pkg::EMIT_STAT;
          cmd.st       = resch_pkg::ST_REJECTED;
        end
        if (cmd.emit_sel != resch_pkg::EMIT_NONE) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_WAIT;
        end
      end
      S_WALK: begin
        resume_nxt = S_IDLE;
        case (sts.func)
          resch_pkg::FN_INSERT, resch_pkg::FN_LIMITED: begin
            if (fin) begin
              if (sts.func == resch_pkg::FN_LIMITED && sts.over_lim) begin
                cmd.emit_sel = resch_pkg::EMIT_STAT;
                cmd.st       = resch_pkg::ST_REJECTED;
              end else begin
                cmd.ins      = 1'b1;
                cmd.emit_sel = resch_pkg::EMIT_NEW;
              end
            end else if (sts.ovl) cmd.slide = 1'b1;
            else cmd.adv = 1'b1;
          end
          resch_pkg::FN_PREEMPT: begin
            if (fin) begin
              cmd.ins      = 1'b1;
              cmd.emit_sel = resch_pkg::EMIT_NEW;
            end else if (sts.ovl) begin
              if (sts.slot_adv) begin
                cmd.emit_sel = resch_pkg::EMIT_STAT;
                cmd.st       = resch_pkg::ST_REJECTED;
              end else begin
                cmd.emit_sel = resch_pkg::EMIT_SLOT;
                cmd.rk       = resch_pkg::RK_EVICT;
                cmd.rem      = 1'b1;
                resume_nxt   = S_WALK;
              end
            end else cmd.adv = 1'b1;
          end
          default: begin
            if (sts.at_end) begin
              cmd.emit_sel = resch_pkg::EMIT_STAT;
              cmd.st       = resch_pkg::ST_NOT_FOUND;
            end else if (sts.id_hit) begin
              cmd.emit_sel = resch_pkg::EMIT_SLOT;
              cmd.rk       = resch_pkg::RK_STATUS;
              cmd.last     = 1'b1;
              cmd.rem      = 1'b1;
            end else cmd.adv = 1'b1;
          end
        endcase
        if (cmd.emit_sel != resch_pkg::EMIT_NONE) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_WAIT;
        end
      end
      S_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = resume_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      resume_r    <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      resume_r    <= resume_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_valid_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_WAIT) else $error("result pending outside wait");
  a_wait_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT && !out_ready) |=> (state_r == S_WAIT && out_valid_r))
    else $error("wait left before result taken");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("request taken while busy");
  a_walk_from_check: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_CHECK || $past(state_r) == S_WALK))
    else $error("result raised from wrong state");
`endif

endmodule

### sv/radio_event_interval_scheduler.sv
// Top level: radio event interval scheduler with request and result channels.
// Keeps up to 16 events in time order and runs one operation per request; one request is
// in work at a time. A request is accepted in the idle state and decoded in the check
// state; an insert or remove then walks the table entry by entry until it decides, and
// every result sits in an output register until taken. A pre-empting insert returns one
// eviction report per removed connection entry before its final status. Insert and remove
// shift the whole table at once, so the time a request takes is set by the walk and by
// every cycle in which the result channel holds ready low.
module radio_event_interval_scheduler (
  input logic               clk,
  input logic               rst_n,
  resch_in_if.sink          in_chan,
  resch_out_if.source       out_chan
);

  resch_pkg::cmd_t cmd;
  resch_pkg::sts_t sts;

  resch_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  resch_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (in_chan.func),
    .in_id          (in_chan.item_id),
    .in_kind        (in_chan.item_kind),
    .in_start       (in_chan.start_tick),
    .in_dur         (in_chan.duration),
    .in_lim         (in_chan.shift_limit),
    .res_kind       (out_chan.result_kind),
    .res_status     (out_chan.status),
    .res_id         (out_chan.entry_id),
    .res_entry_kind (out_chan.entry_kind),
    .res_start      (out_chan.granted_start),
    .res_end        (out_chan.granted_end),
    .res_slide      (out_chan.slide_ticks),
    .res_last       (out_chan.last)
  );

endmodule

### test/resch_test_if.sv
`timescale 1ns / 100ps
// Channel interfaces used by the scheduler testbench are the RTL ones; this file holds the
// testbench-side result and request record types.
package resch_test_pkg;
  import resch_pkg::*;

  typedef struct packed {
    logic                 rk;
    logic [ST_W-1:0]      st;
    logic [ID_W-1:0]      id;
    logic                 kind;
    logic [TIME_BITS-1:0] t_start;
    logic [TIME_BITS-1:0] t_end;
    logic [TIME_BITS-1:0] slide;
    logic                 last;
  } sched_result_t;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [ID_W-1:0]      id;
    logic                 kind;
    logic [TIME_BITS-1:0] t_start;
    logic [TIME_BITS-1:0] dur;
    logic [TIME_BITS-1:0] lim;
  } sched_request_t;
endpackage

### test/radio_event_interval_scheduler_test.sv
`timescale 1ns / 100ps
// Testbench: drives scheduler requests and checks every result against a table model.
module radio_event_interval_scheduler_test;
  import resch_pkg::*;
  import resch_test_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic clk;
  logic rst_n;
  resch_in_if  in_chan ();
  resch_out_if out_chan ();

  radio_event_interval_scheduler i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  // model table
  logic [TIME_BITS-1:0] tbl_start [TABLE_DEPTH];
  logic [TIME_BITS-1:0] tbl_end [TABLE_DEPTH];
  logic [ID_W-1:0]      tbl_id [TABLE_DEPTH];
  logic                 tbl_kind [TABLE_DEPTH];
  int                   tbl_count;

  sched_request_t pending_requests[$];
  sched_result_t  expected_results[$];
  int  failures;
  bit  stimulus_done;
  bit  hold_off;
  bit  quiet_tail;
  int  in_idle, out_stall, idle_cycles;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic before_t(logic [TIME_BITS-1:0] a, logic [TIME_BITS-1:0] b);
    logic [TIME_BITS-1:0] d;
    d = a - b;
    return d[TIME_BITS-1];
  endfunction

  function automatic logic not_after_t(logic [TIME_BITS-1:0] a, logic [TIME_BITS-1:0] b);
    logic [TIME_BITS-1:0] d;
    d = a - b;
    return d == '0 || d[TIME_BITS-1];
  endfunction

  function automatic logic collides(logic [TIME_BITS-1:0] s, logic [TIME_BITS-1:0] e, int i);
    if (before_t(s, tbl_start[i])) return !not_after_t(e, tbl_start[i]);
    return before_t(s, tbl_end[i]);
  endfunction

  function automatic sched_result_t status_only(logic [ST_W-1:0] st);
    sched_result_t r;
    r = '0;
    r.rk = RK_STATUS;
    r.st = st;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic sched_result_t slot_report(int i, logic rk, logic last);
    sched_result_t r;
    r = '0;
    r.rk = rk;
    r.st = ST_OK;
    r.id = tbl_id[i];
    r.kind = tbl_kind[i];
    r.t_start = tbl_start[i];
    r.t_end = tbl_end[i];
    r.last = last;
    return r;
  endfunction

  task automatic place_entry(int pos, logic [TIME_BITS-1:0] s, logic [TIME_BITS-1:0] e,
                             logic [ID_W-1:0] id, logic kind);
    for (int k = tbl_count; k > pos; k--) begin
      tbl_start[k] = tbl_start[k-1];
      tbl_end[k] = tbl_end[k-1];
      tbl_id[k] = tbl_id[k-1];
      tbl_kind[k] = tbl_kind[k-1];
    end
    tbl_start[pos] = s;
    tbl_end[pos] = e;
    tbl_id[pos] = id;
    tbl_kind[pos] = kind;
    tbl_count++;
  endtask

  task automatic drop_entry(int pos);
    for (int k = pos; k + 1 < tbl_count; k++) begin
      tbl_start[k] = tbl_start[k+1];
      tbl_end[k] = tbl_end[k+1];
      tbl_id[k] = tbl_id[k+1];
      tbl_kind[k] = tbl_kind[k+1];
    end
    tbl_count--;
  endtask

  // Apply one request to the model table and queue its results.
  task automatic schedule_request(sched_request_t rq);
    logic [TIME_BITS-1:0] s, e, slide;
    sched_result_t r;
    int pos, i;
    bit done;
    s = rq.t_start;
    e = rq.t_start + rq.dur;
    if (rq.func <= FN_PREEMPT && tbl_count >= TABLE_DEPTH) begin
      expected_results.push_back(status_only(ST_FULL));
      return;
    end
    case (rq.func)
      FN_INSERT, FN_LIMITED: begin
        pos = tbl_count;
        for (i = 0; i < tbl_count; i++) begin
          if (not_after_t(e, tbl_start[i])) begin
            pos = i;
            break;
          end
          if (collides(s, e, i)) begin
            s = tbl_end[i];
            e = s + rq.dur;
          end
        end
        slide = s - rq.t_start;
        if (rq.func == FN_LIMITED && slide > rq.lim) begin
          expected_results.push_back(status_only(ST_REJECTED));
        end else begin
          place_entry(pos, s, e, rq.id, rq.kind);
          r = slot_report(pos, RK_STATUS, 1'b1);
          r.slide = slide;
          expected_results.push_back(r);
        end
      end
      FN_PREEMPT: begin
        i = 0;
        done = 0;
        while (i < tbl_count && !done) begin
          if (not_after_t(e, tbl_start[i])) begin
            done = 1;
          end else if (collides(s, e, i)) begin
            if (tbl_kind[i] == 1'b0) begin
              expected_results.push_back(slot_report(i, RK_EVICT, 1'b0));
              drop_entry(i);
            end else begin
              expected_results.push_back(status_only(ST_REJECTED));
              return;
            end
          end else begin
            i++;
          end
        end
        place_entry(i, s, e, rq.id, rq.kind);
        expected_results.push_back(slot_report(i, RK_STATUS, 1'b1));
      end
      FN_REMOVE: begin
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_id[i] == rq.id) begin
            expected_results.push_back(slot_report(i, RK_STATUS, 1'b1));
            drop_entry(i);
            return;
          end
        end
        expected_results.push_back(status_only(ST_NOT_FOUND));
      end
      FN_POP, FN_PEEK: begin
        if (tbl_count == 0) begin
          expected_results.push_back(status_only(ST_EMPTY));
        end else begin
          expected_results.push_back(slot_report(0, RK_STATUS, 1'b1));
          if (rq.func == FN_POP) drop_entry(0);
        end
      end
      default: expected_results.push_back(status_only(ST_REJECTED));
    endcase
  endtask

  function automatic sched_request_t make_request(logic [FUNC_W-1:0] func, logic [ID_W-1:0] id,
                                                  logic kind, logic [TIME_BITS-1:0] s,
                                                  logic [TIME_BITS-1:0] d,
                                                  logic [TIME_BITS-1:0] lim);
    sched_request_t rq;
    rq.func = func;
    rq.id = id;
    rq.kind = kind;
    rq.t_start = s;
    rq.dur = d;
    rq.lim = lim;
    return rq;
  endfunction

  // Random request: mostly short events near a moving base time, with occasional extremes.
  function automatic sched_request_t random_request(logic [TIME_BITS-1:0] base);
    sched_request_t rq;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) rq.func = FN_INSERT;
    else if (sel < 50) rq.func = FN_LIMITED;
    else if (sel < 65) rq.func = FN_PREEMPT;
    else if (sel < 78) rq.func = FN_REMOVE;
    else if (sel < 90) rq.func = FN_POP;
    else if (sel < 97) rq.func = FN_PEEK;
    else rq.func = FUNC_W'($urandom_range(6, 7));
    rq.id = ID_W'($urandom_range(0, 15));
    if ($urandom_range(0, 9) == 0) rq.id = ID_W'($urandom);
    rq.kind = $urandom_range(0, 3) == 0;
    rq.t_start = base + $urandom_range(0, 400);
    rq.dur = $urandom_range(0, 120);
    rq.lim = $urandom_range(0, 300);
    if ($urandom_range(0, 19) == 0) begin
      rq.t_start = $urandom;
      rq.dur = $urandom;
      rq.lim = $urandom;
    end
    return rq;
  endfunction

  // Fill the request queue.
  initial begin
    logic [TIME_BITS-1:0] base;
    failures = 0;
    tbl_count = 0;
    stimulus_done = 0;
    hold_off = 0;
    quiet_tail = 0;
    rst_n = 1'b0;
    // directed: empty table cases, extremes, every operation
    pending_requests.push_back(make_request(FN_POP, 8'd0, 1'b0, '0, '0, '0));
    pending_requests.push_back(make_request(FN_PEEK, 8'd0, 1'b0, '0, '0, '0));
    pending_requests.push_back(make_request(FN_REMOVE, 8'hff, 1'b0, '0, '0, '0));
    pending_requests.push_back(make_request(FN_INSERT, 8'd1, 1'b0, 32'd100, 32'd50, '0));
    pending_requests.push_back(make_request(FN_INSERT, 8'd2, 1'b1, 32'd120, 32'd10, '0));
    pending_requests.push_back(make_request(FN_LIMITED, 8'd3, 1'b0, 32'd100, 32'd20, 32'd10));
    pending_requests.push_back(make_request(FN_LIMITED, 8'd4, 1'b0, 32'd100, 32'd20, '1));
    pending_requests.push_back(make_request(FN_INSERT, 8'd5, 1'b0, 32'd150, 32'd0, '0));
    pending_requests.push_back(make_request(FN_INSERT, 8'hff, 1'b1, 32'hffff_fff0, 32'h20, '0));
    pending_requests.push_back(make_request(FN_PREEMPT, 8'd6, 1'b0, 32'd90, 32'd25, '0));
    pending_requests.push_back(make_request(FN_PREEMPT, 8'd7, 1'b1, 32'd0, 32'd200, '0));
    pending_requests.push_back(make_request(FN_PEEK, 8'd0, 1'b0, '0, '0, '0));
    pending_requests.push_back(make_request(FN_REMOVE, 8'd2, 1'b0, '0, '0, '0));
    pending_requests.push_back(make_request(FN_PREEMPT, 8'd8, 1'b0, 32'd0, 32'd1000, '0));
    pending_requests.push_back(make_request(3'd6, 8'd0, 1'b0, '1, '1, '1));
    pending_requests.push_back(make_request(3'd7, 8'hff, 1'b1, '0, '0, '0));
    // fill to full, then overflow with every insert kind
    for (int k = 0; k < 17; k++)
      pending_requests.push_back(make_request(FN_INSERT, ID_W'(k), 1'b1, 32'h8000_0000 +
                                              32'(k * 10), 32'd10, '0));
    pending_requests.push_back(make_request(FN_LIMITED, 8'd9, 1'b0, '0, 32'd1, '1));
    pending_requests.push_back(make_request(FN_PREEMPT, 8'd9, 1'b0, '0, 32'd1, '1));
    for (int k = 0; k < 18; k++)
      pending_requests.push_back(make_request(FN_POP, 8'd0, 1'b0, '0, '0, '0));
    base = $urandom;
    for (int k = 0; k < 250; k++) begin
      pending_requests.push_back(random_request(base));
      base = base + $urandom_range(0, 60);
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Drive requests; pause once mid-run until all results are in.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_chan.func <= '0;
      in_chan.item_id <= '0;
      in_chan.item_kind <= 1'b0;
      in_chan.start_tick <= '0;
      in_chan.duration <= '0;
      in_chan.shift_limit <= '0;
      in_idle <= 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        schedule_request(pending_requests.pop_front());
        if (pending_requests.size() == 150) hold_off = 1;
        if (pending_requests.size() == 60) quiet_tail = 1;
      end
      if (hold_off && expected_results.size() == 0 && !(in_chan.valid && !in_chan.ready))
        hold_off = 0;
      if (in_chan.valid && !in_chan.ready) begin
        // hold the transaction
      end else if (pending_requests.size() == 0) begin
        in_chan.valid <= 1'b0;
        stimulus_done <= 1'b1;
      end else if (hold_off || in_idle > 0) begin
        in_chan.valid <= 1'b0;
        if (in_idle > 0) in_idle <= in_idle - 1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        in_chan.valid <= 1'b0;
        in_idle <= $urandom_range(0, 6);
      end else begin
        in_chan.valid <= 1'b1;
        in_chan.func <= pending_requests[0].func;
        in_chan.item_id <= pending_requests[0].id;
        in_chan.item_kind <= pending_requests[0].kind;
        in_chan.start_tick <= pending_requests[0].t_start;
        in_chan.duration <= pending_requests[0].dur;
        in_chan.shift_limit <= pending_requests[0].lim;
      end
    end
  end

  // Take and check results; stall the result channel in bursts.
  always @(posedge clk) begin
    sched_result_t got, want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got.rk = out_chan.result_kind;
        got.st = out_chan.status;
        got.id = out_chan.entry_id;
        got.kind = out_chan.entry_kind;
        got.t_start = out_chan.granted_start;
        got.t_end = out_chan.granted_end;
        got.slide = out_chan.slide_ticks;
        got.last = out_chan.last;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, got);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch expected %h actual %h", $realtime, want, got);
            failures++;
          end
        end
      end
      if (out_stall > 0) begin
        out_chan.ready <= 1'b0;
        out_stall <= out_stall - 1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_chan.ready <= 1'b0;
        out_stall <= $urandom_range(0, 6);
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Watchdog and end of run.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (stimulus_done && expected_results.size() == 0 && idle_cycles >= 40) begin
      if (failures == 0)
        $display("Test completed successfully");
      else
        $display("Test completed with failures");
      $finish;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

### radio_event_interval_scheduler.f
sv/resch_pkg.sv
sv/resch_in_if.sv
sv/resch_out_if.sv
sv/resch_dp.sv
sv/resch_ctrl.sv
sv/radio_event_interval_scheduler.sv
test/resch_test_if.sv
test/radio_event_interval_scheduler_test.sv
